/* rtl/sck_pkg.sv */
// Shared types, widths and register codes for the soft chroma key blender.
// Used by the root cells, the divider cells and the top level.
package sck_pkg;

  localparam int CMAX       = 255;
  localparam int CH_W       = 8;
  localparam int RAD_W      = 9;
  localparam int SQ_W       = 18;
  localparam int X_W        = 34;
  localparam int ROOT_W     = 17;
  localparam int ROOT_CELLS = 17;
  localparam int NUM_W      = 25;
  localparam int DEN_W      = 17;
  localparam int DIV_CELLS  = 8;
  localparam int ADDR_W     = 5;
  localparam int IDX_W      = 3;

  localparam logic [IDX_W-1:0] REG_KEY_RED   = 3'd0;
  localparam logic [IDX_W-1:0] REG_KEY_GREEN = 3'd1;
  localparam logic [IDX_W-1:0] REG_KEY_BLUE  = 3'd2;
  localparam logic [IDX_W-1:0] REG_INNER     = 3'd3;
  localparam logic [IDX_W-1:0] REG_OUTER     = 3'd4;

  typedef struct packed {
    logic [CH_W-1:0] fore_blue;
    logic [CH_W-1:0] fore_green;
    logic [CH_W-1:0] fore_red;
    logic [CH_W-1:0] back_blue;
    logic [CH_W-1:0] back_green;
    logic [CH_W-1:0] back_red;
  } pix_t;

  typedef struct packed {
    pix_t pix;
    logic le_in;
    logic ge_out;
  } item_t;

endpackage

/* rtl/sck_root_cell.sv */
// One digit step of the floor square root, registered, with stall control.
// Depends on sck_pkg.
module sck_root_cell #(
  parameter int K = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  sck_pkg::item_t            in_item,
  input  logic [sck_pkg::X_W-1:0]   in_x,
  input  logic [sck_pkg::X_W-1:0]   in_root,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sck_pkg::item_t            out_item,
  output logic [sck_pkg::X_W-1:0]   out_x,
  output logic [sck_pkg::X_W-1:0]   out_root
);
  import sck_pkg::*;

  logic [X_W-1:0] bitv;
  logic [X_W-1:0] trial;
  logic [X_W-1:0] x_next;
  logic [X_W-1:0] root_next;

  assign in_ready = !out_valid || out_ready;
  assign bitv     = X_W'(1) << (2 * K);
  assign trial    = in_root + bitv;

  always_comb begin
    if (in_x >= trial) begin
      x_next    = in_x - trial;
      root_next = (in_root >> 1) + bitv;
    end else begin
      x_next    = in_x;
      root_next = in_root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_item <= in_item;
      out_x    <= x_next;
      out_root <= root_next;
    end
  end

endmodule

/* rtl/sck_div_cell.sv */
// One quotient bit of the restoring ramp divider, registered, with stall control.
// Depends on sck_pkg.
module sck_div_cell #(
  parameter int K = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [sck_pkg::DEN_W-1:0]   den,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  sck_pkg::item_t              in_item,
  input  logic [sck_pkg::NUM_W-1:0]   in_rem,
  input  logic [sck_pkg::CH_W-1:0]    in_quo,
  output logic                        out_valid,
  input  logic                        out_ready,
  output sck_pkg::item_t              out_item,
  output logic [sck_pkg::NUM_W-1:0]   out_rem,
  output logic [sck_pkg::CH_W-1:0]    out_quo
);
  import sck_pkg::*;

  logic [NUM_W-1:0] dsh;
  logic [NUM_W-1:0] rem_next;
  logic [CH_W-1:0]  quo_next;

  assign in_ready = !out_valid || out_ready;
  assign dsh      = NUM_W'(den) << K;

  always_comb begin
    if (in_rem >= dsh) begin
      rem_next = in_rem - dsh;
      quo_next = in_quo | (CH_W'(1) << K);
    end else begin
      rem_next = in_rem;
      quo_next = in_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_item <= in_item;
      out_rem  <= rem_next;
      out_quo  <= quo_next;
    end
  end

endmodule

/* rtl/soft_chroma_key_blend.sv */
// Soft chroma key blender: distance, root cells, divider cells and mixer.
// One pixel pair per cycle while m_tready allows; the pipeline holds two front stages,
// 17 root cells, one numerator stage, 8 divider cells and two output stages.
// Every stage holds only while its successor is full and stalled.
// Reset (rst, synchronous) empties the pipeline and loads register defaults.
module soft_chroma_key_blend (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // back_red, back_green, back_blue, fore_red, fore_green, fore_blue
  input  logic [47:0]                 s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // out_red, out_green, out_blue, alpha
  output logic [31:0]                 m_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sck_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import sck_pkg::*;

  logic [CH_W-1:0]  key_red, key_green, key_blue;
  logic [RAD_W-1:0] inner_radius, outer_radius;
  logic [SQ_W-1:0]  in2, out2;
  logic [IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_red      <= '0;
      key_green    <= 8'd255;
      key_blue     <= '0;
      inner_radius <= '0;
      outer_radius <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        REG_KEY_RED:   key_red      <= pwdata[CH_W-1:0];
        REG_KEY_GREEN: key_green    <= pwdata[CH_W-1:0];
        REG_KEY_BLUE:  key_blue     <= pwdata[CH_W-1:0];
        REG_INNER:     inner_radius <= pwdata[RAD_W-1:0];
        REG_OUTER:     outer_radius <= pwdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KEY_RED:   prdata = 32'(key_red);
      REG_KEY_GREEN: prdata = 32'(key_green);
      REG_KEY_BLUE:  prdata = 32'(key_blue);
      REG_INNER:     prdata = 32'(inner_radius);
      REG_OUTER:     prdata = 32'(outer_radius);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    in2 <= SQ_W'(inner_radius) * SQ_W'(inner_radius);
    out2 <= SQ_W'(outer_radius) * SQ_W'(outer_radius);
  end

  logic [DEN_W-1:0] den;
  logic [RAD_W-1:0] span;
  assign span = outer_radius - inner_radius;
  assign den  = {span, 8'd0};

  // stage 1: channel differences squared
  pix_t in_pix;
  assign in_pix = pix_t'(s_tdata);

  logic [CH_W-1:0]   dr, dg, db;
  logic              v1, rdy1;
  pix_t              p1;
  logic [2*CH_W-1:0] sqr, sqg, sqb;

  assign dr = (in_pix.fore_red >= key_red) ? in_pix.fore_red - key_red
                                           : key_red - in_pix.fore_red;
  assign dg = (in_pix.fore_green >= key_green) ? in_pix.fore_green - key_green
                                               : key_green - in_pix.fore_green;
  assign db = (in_pix.fore_blue >= key_blue) ? in_pix.fore_blue - key_blue
                                             : key_blue - in_pix.fore_blue;

  logic v2, rdy2;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      p1  <= in_pix;
      sqr <= dr * dr;
      sqg <= dg * dg;
      sqb <= db * db;
    end
  end

  // stage 2: squared distance and band tests
  logic [SQ_W-1:0] sq;
  item_t           it2;
  logic            root_rdy;

  assign sq   = SQ_W'(sqr) + SQ_W'(sqg) + SQ_W'(sqb);
  assign rdy2 = !v2 || root_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  logic [SQ_W-1:0] sq2;
  always_ff @(posedge clk) begin
    if (rdy2) begin
      it2.pix    <= p1;
      it2.le_in  <= (sq <= in2);
      it2.ge_out <= (sq >= out2);
      sq2        <= sq;
    end
  end

  // root cells, most significant digit first
  logic             rv   [ROOT_CELLS+1];
  logic             rr   [ROOT_CELLS+1];
  item_t            ri   [ROOT_CELLS+1];
  logic [X_W-1:0]   rx   [ROOT_CELLS+1];
  logic [X_W-1:0]   rrt  [ROOT_CELLS+1];

  assign rv[0]    = v2;
  assign ri[0]    = it2;
  assign rx[0]    = {sq2, 16'd0};
  assign rrt[0]   = '0;
  assign root_rdy = rr[0];

  for (genvar g = 0; g < ROOT_CELLS; g++) begin : g_root
    sck_root_cell #(.K(ROOT_CELLS - 1 - g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (rv[g]),
      .in_ready  (rr[g]),
      .in_item   (ri[g]),
      .in_x      (rx[g]),
      .in_root   (rrt[g]),
      .out_valid (rv[g+1]),
      .out_ready (rr[g+1]),
      .out_item  (ri[g+1]),
      .out_x     (rx[g+1]),
      .out_root  (rrt[g+1])
    );
  end

  // stage 3: ramp numerator
  logic              v3, rdy3, div_rdy;
  item_t             it3;
  logic [NUM_W-1:0]  num3;
  logic [ROOT_W-1:0] root_d;
  logic [ROOT_W-1:0] od;

  assign root_d = rrt[ROOT_CELLS][ROOT_W-1:0];
  assign od     = {outer_radius, 8'd0} - root_d;
  assign rdy3   = !v3 || div_rdy;
  assign rr[ROOT_CELLS] = rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= rv[ROOT_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      it3  <= ri[ROOT_CELLS];
      num3 <= (NUM_W'(od) << 8) - NUM_W'(od);
    end
  end

  // divider cells, most significant quotient bit first
  logic             dv  [DIV_CELLS+1];
  logic             dr_ [DIV_CELLS+1];
  item_t            di  [DIV_CELLS+1];
  logic [NUM_W-1:0] drm [DIV_CELLS+1];
  logic [CH_W-1:0]  dq  [DIV_CELLS+1];

  assign dv[0]   = v3;
  assign di[0]   = it3;
  assign drm[0]  = num3;
  assign dq[0]   = '0;
  assign div_rdy = dr_[0];

  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
    sck_div_cell #(.K(DIV_CELLS - 1 - g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .den       (den),
      .in_valid  (dv[g]),
      .in_ready  (dr_[g]),
      .in_item   (di[g]),
      .in_rem    (drm[g]),
      .in_quo    (dq[g]),
      .out_valid (dv[g+1]),
      .out_ready (dr_[g+1]),
      .out_item  (di[g+1]),
      .out_rem   (drm[g+1]),
      .out_quo   (dq[g+1])
    );
  end

  // stage 4: alpha select and channel products
  logic              v4, rdy4, v5, rdy5;
  item_t             it_d;
  logic [CH_W-1:0]   a_sel, a_inv, alpha4;
  logic [2*CH_W-1:0] pbr, pbg, pbb, pfr, pfg, pfb;

  assign it_d = di[DIV_CELLS];
  always_comb begin
    if (it_d.le_in) begin
      a_sel = 8'd255;
    end else if (it_d.ge_out) begin
      a_sel = '0;
    end else begin
      a_sel = dq[DIV_CELLS];
    end
  end
  assign a_inv = 8'd255 - a_sel;
  assign rdy4  = !v4 || rdy5;
  assign dr_[DIV_CELLS] = rdy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= dv[DIV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      alpha4 <= a_sel;
      pbr    <= it_d.pix.back_red * a_sel;
      pbg    <= it_d.pix.back_green * a_sel;
      pbb    <= it_d.pix.back_blue * a_sel;
      pfr    <= it_d.pix.fore_red * a_inv;
      pfg    <= it_d.pix.fore_green * a_inv;
      pfb    <= it_d.pix.fore_blue * a_inv;
    end
  end

  // stage 5: divide by 255 and output register
  function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] a,
                                             input logic [2*CH_W-1:0] b);
    logic [2*CH_W:0] s;
    logic [2*CH_W:0] t;
    s = (2*CH_W+1)'(a) + (2*CH_W+1)'(b);
    t = s + (s >> 8) + (2*CH_W+1)'(1);
    return t[2*CH_W-1:CH_W];
  endfunction

  assign rdy5 = !v5 || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (rdy5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      m_tdata <= {alpha4, div255(pbb, pfb), div255(pbg, pfg), div255(pbr, pfr)};
    end
  end

  assign m_tvalid = v5;

  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready) else $error("input stalled while output drains");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid) else $error("output valid right after reset");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("output changed while stalled");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for soft_chroma_key_blend: streams pixel pairs with
// random idling, predicts alpha and the blended channels, checks every transfer.
// Depends on sck_pkg and the soft_chroma_key_blend RTL.
`timescale 1ns / 1ps

module testbench;
  import sck_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;  // back_red, back_green, back_blue, fore_red, fore_green, fore_blue
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;  // out_red, out_green, out_blue, alpha
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [7:0] key_r, key_g, key_b;
  logic [8:0] rad_in, rad_out;
  logic [31:0] blend_q[$];
  int errors;
  bit calm;
  bit out_calm;

  soft_chroma_key_blend DUT (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [7:0] key_weight(logic [7:0] fr, logic [7:0] fg, logic [7:0] fb);
    longint dr, dg, db, sq, x, root, bitv, num, den, a;
    dr = longint'(fr) - key_r;
    dg = longint'(fg) - key_g;
    db = longint'(fb) - key_b;
    sq = dr * dr + dg * dg + db * db;
    if (sq <= longint'(rad_in) * rad_in) return 8'd255;
    if (sq >= longint'(rad_out) * rad_out) return 8'd0;
    x = sq << 16;
    root = 0;
    bitv = 64'h1 << 40;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    num = 255 * (longint'(rad_out) * 256 - root);
    den = (longint'(rad_out) - rad_in) * 256;
    a = num / den;
    if (a > 255) a = 255;
    return a[7:0];
  endfunction

  function automatic logic [31:0] blend_pixel(logic [47:0] p);
    logic [7:0] a, c[3];
    int v;
    a = key_weight(p[31:24], p[39:32], p[47:40]);
    for (int i = 0; i < 3; i++) begin
      v = (int'(p[8*i +: 8]) * a + int'(p[24 + 8*i +: 8]) * (255 - a)) / 255;
      c[i] = (v > 255) ? 8'd255 : v[7:0];
    end
    return {a, c[2], c[1], c[0]};
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_KEY_RED:   key_r = val[7:0];
      REG_KEY_GREEN: key_g = val[7:0];
      REG_KEY_BLUE:  key_b = val[7:0];
      REG_INNER:     rad_in = val[8:0];
      REG_OUTER:     rad_out = val[8:0];
      default: ;
    endcase
  endtask

  task automatic set_key(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                         logic [8:0] ri, logic [8:0] ro);
    write_reg(REG_KEY_RED, 32'(r));
    write_reg(REG_KEY_GREEN, 32'(g));
    write_reg(REG_KEY_BLUE, 32'(b));
    write_reg(REG_INNER, 32'(ri));
    write_reg(REG_OUTER, 32'(ro));
  endtask

  task automatic send_pixel(logic [47:0] p);
    if (!calm)
      while ($urandom_range(99) < 29) begin
        s_tvalid <= 0;
        @(posedge clk);
      end
    s_tvalid <= 1;
    s_tdata <= p;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    blend_q.push_back(blend_pixel(p));
  endtask

  task automatic drain;
    s_tvalid <= 0;
    while (blend_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [47:0] near_key();
    logic [7:0] f[3], k[3];
    int v;
    k[0] = key_r; k[1] = key_g; k[2] = key_b;
    for (int i = 0; i < 3; i++) begin
      v = int'(k[i]) + $signed($urandom_range(160)) - 80;
      f[i] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
    end
    return {f[2], f[1], f[0], 24'($urandom)};
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      m_tready <= out_calm || ($urandom_range(99) >= 29);
      if (m_tvalid && m_tready) begin
        if (blend_q.size() == 0) begin
          $display("%0t unexpected transfer: expected none, actual %h", $time, m_tdata);
          errors++;
        end else begin
          logic [31:0] e;
          e = blend_q.pop_front();
          for (int i = 0; i < 4; i++)
            if (e[8*i +: 8] !== m_tdata[8*i +: 8]) begin
              $display("%0t field %0d: expected %0d, actual %0d", $time, i,
                       e[8*i +: 8], m_tdata[8*i +: 8]);
              errors++;
            end
        end
      end
    end
  end

  task automatic test_reset_defaults;
    key_r = 0; key_g = 255; key_b = 0; rad_in = 0; rad_out = 0;
    send_pixel({8'd0, 8'd255, 8'd0, 24'h123456});
    send_pixel({8'd255, 8'd0, 8'd255, 24'hABCDEF});
    drain();
  endtask

  task automatic test_extremes;
    set_key(8'd0, 8'd0, 8'd0, 9'd0, 9'd511);
    send_pixel(48'h0);
    send_pixel({48{1'b1}});
    send_pixel({24'hFFFFFF, 24'h000000});
    send_pixel({24'h000000, 24'hFFFFFF});
    send_pixel({24'h808080, 24'h7F7F7F});
    drain();
    set_key(8'd255, 8'd255, 8'd255, 9'd511, 9'd511);
    send_pixel(48'h0);
    send_pixel({48{1'b1}});
    drain();
  endtask

  task automatic test_ramp_edges;
    set_key(8'd100, 8'd100, 8'd100, 9'd10, 9'd20);
    send_pixel({8'd100, 8'd100, 8'd110, 24'h00FF80});
    send_pixel({8'd100, 8'd100, 8'd111, 24'h00FF80});
    send_pixel({8'd100, 8'd100, 8'd119, 24'h00FF80});
    send_pixel({8'd100, 8'd100, 8'd120, 24'h00FF80});
    send_pixel({8'd105, 8'd105, 8'd105, 24'hFF00FF});
    drain();
    // inner above outer: no ramp
    set_key(8'd50, 8'd60, 8'd70, 9'd30, 9'd5);
    send_pixel({8'd70, 8'd60, 8'd80, 24'h112233});
    send_pixel({8'd70, 8'd60, 8'd50, 24'h445566});
    send_pixel({8'd200, 8'd60, 8'd50, 24'h778899});
    drain();
  endtask

  task automatic test_random_stream(int n);
    for (int s = 0; s < 5; s++) begin
      set_key(8'($urandom), 8'($urandom), 8'($urandom),
              9'($urandom_range(120)), 9'($urandom_range(511)));
      for (int i = 0; i < n; i++) begin
        calm = (i >= n / 3 && i < n / 2);
        out_calm = calm;
        send_pixel(($urandom_range(3) == 0) ? 48'({$urandom, $urandom}) : near_key());
      end
      calm = 0;
      out_calm = 0;
      drain();
    end
  endtask

  initial begin
    errors = 0; calm = 0; out_calm = 0;
    rst = 1; s_tvalid = 0; s_tdata = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    test_reset_defaults();
    test_extremes();
    test_ramp_edges();
    test_random_stream(200);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/sck_pkg.sv
rtl/sck_root_cell.sv
rtl/sck_div_cell.sv
rtl/soft_chroma_key_blend.sv
tb/sv/testbench.sv
